### rtl/core/prbp_pkg.sv
package prbp_pkg;

    // default pad buffer size in bytes
    localparam int unsigned PAD_MAX_BYTES_DEF = 512;

    // field widths
    localparam int unsigned PAD_LEN_W   = 10;
    localparam int unsigned COUNT_W     = 32;
    localparam int unsigned OFFSET_W    = 9;
    localparam int unsigned SLOT_W      = 16;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned OUT_TDATA_W = 48;

    // input commands
    typedef enum logic [1:0] {
        CMD_BEGIN    = 2'd0,
        CMD_DATA     = 2'd1,
        CMD_PAD_DONE = 2'd2
    } t_cmd;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_PAD_READY = 2'd1;
    localparam logic [1:0] ST_ERROR     = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_MAX      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BODY_COUNT   = 2'd2;

    typedef struct packed {
        logic                 decrypt_mode;
        logic [PAD_LEN_W-1:0] pad_max;
        logic [COUNT_W-1:0]   body_count;
    } t_cfg;

    typedef struct packed {
        logic [1:0]           status;
        logic                 consumed;
        logic                 payload_valid;
        logic [7:0]           payload_byte;
        logic [OFFSET_W-1:0]  payload_offset;
        logic [PAD_LEN_W-1:0] pad_length;
        logic [SLOT_W-1:0]    record_slot;
    } t_result;

endpackage

### rtl/core/prbp_cfg_regs.sv
module prbp_cfg_regs
    import prbp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    logic                 r_decrypt_mode;
    logic [PAD_LEN_W-1:0] r_pad_max;
    logic [COUNT_W-1:0]   r_body_count;

    // register writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrypt_mode <= 1'b0;
            r_pad_max      <= '0;
            r_body_count   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DECRYPT_MODE: r_decrypt_mode <= i_cfg_wdata[0];
                CFG_PAD_MAX:      r_pad_max      <= i_cfg_wdata[PAD_LEN_W-1:0];
                CFG_BODY_COUNT:   r_body_count   <= i_cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.decrypt_mode = r_decrypt_mode;
    assign o_cfg.pad_max      = r_pad_max;
    assign o_cfg.body_count   = r_body_count;

endmodule

### rtl/core/prbp_step.sv
module prbp_step
    import prbp_pkg::*;
#(
    parameter int unsigned PAD_MAX_BYTES = PAD_MAX_BYTES_DEF
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output t_result    o_res
);

    localparam int unsigned PAD_LEN_MAX = (1 << PAD_LEN_W) - 1;
    localparam logic [PAD_LEN_W-1:0] CLAMP_MAX =
        (PAD_MAX_BYTES > PAD_LEN_MAX) ? PAD_LEN_W'(PAD_LEN_MAX) : PAD_LEN_W'(PAD_MAX_BYTES);

    logic                 r_mode_dec,    n_mode_dec;
    logic [PAD_LEN_W-1:0] r_apm,         n_apm;
    logic [COUNT_W-1:0]   r_count_left,  n_count_left;
    logic [2:0]           r_hdr_got,     n_hdr_got;
    logic [23:0]          r_hdr_partial, n_hdr_partial;
    logic [SLOT_W-1:0]    r_slot,        n_slot;
    logic [PAD_LEN_W-1:0] r_bytes_got,   n_bytes_got;
    logic [PAD_LEN_W-1:0] r_bytes_need,  n_bytes_need;
    logic                 r_pad_ready,   n_pad_ready;

    logic [PAD_LEN_W-1:0] w_cfg_apm;
    logic [PAD_LEN_W-1:0] w_begin_len;
    logic [PAD_LEN_W-1:0] w_plain_len;
    logic [15:0]          w_hdr_len;
    logic                 w_hdr_bad;
    logic [PAD_LEN_W-1:0] w_got_inc;

    // clamp of the pad limit and first plaintext pad length on begin
    assign w_cfg_apm   = (i_cfg.pad_max > CLAMP_MAX) ? CLAMP_MAX : i_cfg.pad_max;
    assign w_begin_len = (i_cfg.body_count > {{(COUNT_W-PAD_LEN_W){1'b0}}, w_cfg_apm})
                         ? w_cfg_apm : i_cfg.body_count[PAD_LEN_W-1:0];
    assign w_plain_len = (r_count_left > {{(COUNT_W-PAD_LEN_W){1'b0}}, r_apm})
                         ? r_apm : r_count_left[PAD_LEN_W-1:0];

    // record header length check on the fourth header byte
    assign w_hdr_len = {i_byte, r_hdr_partial[23:16]};
    assign w_hdr_bad = (w_hdr_len == 16'd0)
                    || (w_hdr_len > {{(16-PAD_LEN_W){1'b0}}, r_apm})
                    || ((r_count_left > 32'd1)
                        && (w_hdr_len != {{(16-PAD_LEN_W){1'b0}}, r_apm}));
    assign w_got_inc = r_bytes_got + PAD_LEN_W'(1);

    // next state and result for one word
    always_comb begin
        n_mode_dec    = r_mode_dec;
        n_apm         = r_apm;
        n_count_left  = r_count_left;
        n_hdr_got     = r_hdr_got;
        n_hdr_partial = r_hdr_partial;
        n_slot        = r_slot;
        n_bytes_got   = r_bytes_got;
        n_bytes_need  = r_bytes_need;
        n_pad_ready   = r_pad_ready;
        o_res.status         = ST_OK;
        o_res.consumed       = 1'b0;
        o_res.payload_valid  = 1'b0;
        o_res.payload_byte   = 8'd0;
        o_res.payload_offset = '0;

        case (i_cmd)
            CMD_BEGIN: begin
                n_mode_dec    = i_cfg.decrypt_mode;
                n_apm         = w_cfg_apm;
                n_count_left  = i_cfg.body_count;
                n_hdr_got     = 3'd0;
                n_hdr_partial = '0;
                n_slot        = '0;
                n_bytes_got   = '0;
                n_pad_ready   = 1'b0;
                n_bytes_need  = i_cfg.decrypt_mode ? '0 : w_begin_len;
            end
            CMD_PAD_DONE: begin
                n_hdr_got     = 3'd0;
                n_hdr_partial = '0;
                n_slot        = '0;
                n_bytes_got   = '0;
                n_pad_ready   = 1'b0;
                n_bytes_need  = r_mode_dec ? '0 : w_plain_len;
            end
            CMD_DATA: begin
                if (r_pad_ready) begin
                    o_res.status = ST_PAD_READY;
                end else if (r_apm == '0 || r_count_left == '0) begin
                    // no body active: drop everything
                    n_mode_dec    = 1'b0;
                    n_apm         = '0;
                    n_count_left  = '0;
                    n_hdr_got     = 3'd0;
                    n_hdr_partial = '0;
                    n_slot        = '0;
                    n_bytes_got   = '0;
                    n_bytes_need  = '0;
                    o_res.status  = ST_ERROR;
                end else if (r_mode_dec && r_hdr_got < 3'd4 && r_bytes_need == '0) begin
                    if (r_hdr_got < 3'd3) begin
                        case (r_hdr_got)
                            3'd0:    n_hdr_partial = r_hdr_partial | {16'd0, i_byte};
                            3'd1:    n_hdr_partial = r_hdr_partial | {8'd0, i_byte, 8'd0};
                            default: n_hdr_partial = r_hdr_partial | {i_byte, 16'd0};
                        endcase
                        n_hdr_got      = r_hdr_got + 3'd1;
                        o_res.consumed = 1'b1;
                    end else if (w_hdr_bad) begin
                        n_mode_dec    = 1'b0;
                        n_apm         = '0;
                        n_count_left  = '0;
                        n_hdr_got     = 3'd0;
                        n_hdr_partial = '0;
                        n_slot        = '0;
                        n_bytes_got   = '0;
                        n_bytes_need  = '0;
                        o_res.status  = ST_ERROR;
                    end else begin
                        n_hdr_got      = 3'd4;
                        n_slot         = r_hdr_partial[15:0];
                        n_bytes_need   = w_hdr_len[PAD_LEN_W-1:0];
                        n_bytes_got    = '0;
                        o_res.consumed = 1'b1;
                    end
                end else if (r_bytes_need != '0) begin
                    // payload byte goes straight out
                    o_res.payload_valid  = 1'b1;
                    o_res.payload_byte   = i_byte;
                    o_res.payload_offset = r_bytes_got[OFFSET_W-1:0];
                    o_res.consumed       = 1'b1;
                    n_bytes_got          = w_got_inc;
                    if (w_got_inc >= r_bytes_need) begin
                        n_pad_ready  = 1'b1;
                        o_res.status = ST_PAD_READY;
                        n_count_left = r_mode_dec
                            ? (r_count_left - 32'd1)
                            : (r_count_left - {{(COUNT_W-PAD_LEN_W){1'b0}}, r_bytes_need});
                    end
                end
            end
            default: begin
                o_res.status = r_pad_ready ? ST_PAD_READY : ST_OK;
            end
        endcase

        o_res.pad_length  = n_pad_ready ? n_bytes_need : '0;
        o_res.record_slot = n_slot;
    end

    // body state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_dec    <= 1'b0;
            r_apm         <= '0;
            r_count_left  <= '0;
            r_hdr_got     <= 3'd0;
            r_hdr_partial <= '0;
            r_slot        <= '0;
            r_bytes_got   <= '0;
            r_bytes_need  <= '0;
            r_pad_ready   <= 1'b0;
        end else if (i_en) begin
            r_mode_dec    <= n_mode_dec;
            r_apm         <= n_apm;
            r_count_left  <= n_count_left;
            r_hdr_got     <= n_hdr_got;
            r_hdr_partial <= n_hdr_partial;
            r_slot        <= n_slot;
            r_bytes_got   <= n_bytes_got;
            r_bytes_need  <= n_bytes_need;
            r_pad_ready   <= n_pad_ready;
        end
    end

endmodule

### rtl/core/pad_record_body_parser.sv
// a word accepted into the input register is stepped into the result register and offered from there as a result word
// throughput: one word per cycle, held back only by a stalled result word
// an input register and a result register bracket the combinational step logic
// reset: synchronous active-low i_rst_n clears config, body state and both valid flags
module pad_record_body_parser
    import prbp_pkg::*;
#(
    parameter int unsigned PAD_MAX_BYTES = PAD_MAX_BYTES_DEF
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // input stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [7:0]             i_s_tdata,   // data_byte[7:0]
    input  logic [1:0]             i_s_tuser,   // command[1:0]
    // result stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // consumed[0], payload_valid[1], payload_byte[9:2], payload_offset[18:10],
    // pad_length[28:19], record_slot[44:29], zero[47:45]
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic [1:0]             o_m_tuser    // status[1:0]
);

    t_cfg       w_cfg;
    t_result    w_res;
    logic       w_adv;
    logic       w_step;

    logic       r_in_valid;
    logic [1:0] r_cmd;
    logic [7:0] r_byte;
    logic       r_out_valid;
    t_result    r_res;

    prbp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // the result register takes a new word when empty or being drained
    assign w_adv      = !r_out_valid || i_m_tready;
    assign w_step     = r_in_valid && w_adv;
    assign o_s_tready = !r_in_valid || w_adv;

    prbp_step #(
        .PAD_MAX_BYTES (PAD_MAX_BYTES)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_step),
        .i_cmd   (r_cmd),
        .i_byte  (r_byte),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_cmd  <= i_s_tuser;
            r_byte <= i_s_tdata;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_res <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_res.status;
    assign o_m_tdata  = {3'b000, r_res.record_slot, r_res.pad_length, r_res.payload_offset,
                         r_res.payload_byte, r_res.payload_valid, r_res.consumed};

    // a stalled result word is never dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_tready |=> r_out_valid)
        else $error("result word lost under stall");

    // a waiting input word is never dropped
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_cmd) && $stable(r_byte))
        else $error("input word lost or changed while waiting");

    // payload is only echoed for a taken byte
    a_payload_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_res.payload_valid |-> r_res.consumed)
        else $error("payload flagged for a byte not taken");

    // an error never takes the byte
    a_error_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_res.status == ST_ERROR |-> !r_res.consumed && !r_res.payload_valid)
        else $error("byte taken on parse error");

    // pad ready status goes with a nonzero pad length
    a_pad_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((r_res.status == ST_PAD_READY) == (r_res.pad_length != '0)))
        else $error("pad length does not match pad ready status");

endmodule
